// ----- sv/nmearmc_pkg.sv -----
package nmearmc_pkg;

   localparam int LINE_LIMIT = 128;
   localparam int MAX_FIELDS = 16;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_STATUS_OK = 8'h41;

   localparam logic [4:0] FLD_TYPE   = 5'd0;
   localparam logic [4:0] FLD_TIME   = 5'd1;
   localparam logic [4:0] FLD_STATUS = 5'd2;
   localparam logic [4:0] FLD_LAT    = 5'd3;
   localparam logic [4:0] FLD_LON    = 5'd5;
   localparam logic [4:0] FLD_DATE   = 5'd9;

   localparam logic [2:0] TYPE_DONE = 3'd5;
   localparam logic [2:0] TYPE_BAD  = 3'd6;
   localparam logic [2:0] SUM_DONE  = 3'd2;
   localparam logic [2:0] SUM_BAD   = 3'd7;

   localparam logic [2:0] COORD_FRAC_END = 3'd5;
   localparam logic [1:0] TIME_FRAC_END  = 2'd3;

   localparam logic [29:0] LAT_CAP   = 30'd99999999;
   localparam logic [29:0] LON_CAP   = 30'd999999999;
   localparam logic [11:0] YEAR_BASE = 12'd2000;

   localparam int RSP_TDATA_W = 112;

   typedef logic [3:0] digit_type;
   typedef logic [5:0][3:0] six_digit_type;

   typedef struct packed {
      logic [29:0] longitude;
      logic [26:0] latitude;
      logic [11:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hundredths;
      logic [6:0]  second;
      logic [6:0]  minute;
      logic [6:0]  hour;
   } rsp_data_type;

   typedef struct packed {
      logic         updated;
      rsp_data_type data;
   } rsp_item_type;

   function automatic logic [7:0] type_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h47;
         3'd1:    ch = 8'h50;
         3'd2:    ch = 8'h52;
         3'd3:    ch = 8'h4D;
         3'd4:    ch = 8'h43;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] two_digits(input digit_type tens, input digit_type units);
      logic [6:0] t;
      t = {3'b000, tens};
      return (t << 3) + (t << 1) + {3'b000, units};
   endfunction

   // integer digits scale the whole value by ten, fraction digits add at their weight
   function automatic logic [29:0] coord_step(input logic [29:0] acc, input logic [2:0] fc,
                                              input digit_type d, input logic [29:0] cap);
      logic [34:0] wide;
      logic [34:0] sum;
      logic [34:0] weight;
      wide = {5'b00000, acc};
      unique case (fc)
         3'd1:    weight = 35'd1000;
         3'd2:    weight = 35'd100;
         3'd3:    weight = 35'd10;
         default: weight = 35'd1;
      endcase
      if (fc == 3'd0) begin
         sum = (wide << 3) + (wide << 1) + ({31'd0, d} * 35'd10000);
      end else begin
         sum = wide + ({31'd0, d} * weight);
      end
      return (sum > {5'b00000, cap}) ? cap : sum[29:0];
   endfunction

endpackage

// ----- sv/nmearmc_rsp_buf.sv -----
module nmearmc_rsp_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nmearmc_pkg::rsp_item_type  push_item,
   output logic                       in_ready,
   output logic                       out_valid,
   output nmearmc_pkg::rsp_item_type  out_item,
   input  logic                       out_ready
);
   import nmearmc_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop       = main_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff) begin
         if (push) begin
            main_valid_in = 1'b1;
            main_in       = push_item;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_item;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- sv/nmea_rmc_sentence_parser_unit.sv -----
// NMEA RMC sentence parser.
// Input channel req_*: one received character per transfer in req_tdata.
// '$' starts a sentence, '\n' is ignored, '\r' closes it and produces one
// result; characters past the line limit are dropped.
// Result channel rsp_*: rsp_tuser is set when the sentence was a checked GPRMC
// with status A and replaced the kept time, date and coordinates; rsp_tdata
// always carries the kept values (the fresh ones when rsp_tuser is set).
// Unless the output stalls, the result is valid in the cycle after the '\r' transfer.
// Throughput: one character per cycle unless the skid is full; every character is
// handled by one layer of logic between the sentence state registers and the result
// register, including the multiply-by-ten of the coordinate accumulators.
// A stalled receiver holds the result in the output register while a skid
// register takes one more; req_tready drops only while the skid is full.
// Reset clears the sentence state, empties both result registers and sets
// the kept values to zero with year 2000.
module nmea_rmc_sentence_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // char_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hour, minute, second, hundredths, day, month, year, latitude, longitude
   output logic [nmearmc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tuser   // updated
);
   import nmearmc_pkg::*;

   logic          accept;
   logic [7:0]    ch;
   digit_type     dig;
   logic          is_digit;
   logic          hex_ok;
   logic [3:0]    hex_val;

   logic [7:0]    char_count_ff, char_count_in;
   logic [4:0]    field_ff, field_in;
   logic [7:0]    xor_ff, xor_in;
   logic          after_star_ff, after_star_in;
   logic [7:0]    rx_sum_ff, rx_sum_in;
   logic [2:0]    sum_cnt_ff, sum_cnt_in;
   logic [2:0]    type_ff, type_in;
   logic          status_a_ff, status_a_in;
   logic [1:0]    status_len_ff, status_len_in;
   six_digit_type time_ff, time_in;
   logic [1:0]    time_fc_ff, time_fc_in;
   digit_type     frac1_ff, frac1_in;
   digit_type     frac2_ff, frac2_in;
   six_digit_type date_ff, date_in;
   logic [26:0]   lat_ff, lat_in;
   logic [2:0]    lat_fc_ff, lat_fc_in;
   logic [29:0]   lon_ff, lon_in;
   logic [2:0]    lon_fc_ff, lon_fc_in;
   rsp_data_type  kept_ff, kept_in;

   logic          clear;
   logic          ok;
   logic          push;
   rsp_data_type  fresh;
   rsp_item_type  push_item;
   rsp_item_type  out_item;
   logic          buf_ready;

   assign accept   = req_tvalid & req_tready;
   assign ch       = req_tdata;
   assign dig      = ch[3:0];
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign hex_ok   = is_digit || ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F));
   assign hex_val  = is_digit ? ch[3:0] : (ch[3:0] + 4'd9);

   always_comb begin
      fresh.hour   = two_digits(time_ff[5], time_ff[4]);
      fresh.minute = two_digits(time_ff[3], time_ff[2]);
      fresh.second = two_digits(time_ff[1], time_ff[0]);
      unique case (time_fc_ff)
         2'd2:    fresh.hundredths = two_digits(frac1_ff, 4'd0);
         2'd3:    fresh.hundredths = two_digits(frac1_ff, frac2_ff);
         default: fresh.hundredths = 7'd0;
      endcase
      fresh.day       = two_digits(date_ff[5], date_ff[4]);
      fresh.month     = two_digits(date_ff[3], date_ff[2]);
      fresh.year      = YEAR_BASE + {5'd0, two_digits(date_ff[1], date_ff[0])};
      fresh.latitude  = lat_ff;
      fresh.longitude = lon_ff;
   end

   assign ok = (type_ff == TYPE_DONE) && status_a_ff && (status_len_ff == 2'd1) &&
               after_star_ff && (sum_cnt_ff == SUM_DONE) && (rx_sum_ff == xor_ff);

   assign push_item.updated = ok;
   assign push_item.data    = ok ? fresh : kept_ff;

   always_comb begin
      char_count_in = char_count_ff;
      field_in      = field_ff;
      xor_in        = xor_ff;
      after_star_in = after_star_ff;
      rx_sum_in     = rx_sum_ff;
      sum_cnt_in    = sum_cnt_ff;
      type_in       = type_ff;
      status_a_in   = status_a_ff;
      status_len_in = status_len_ff;
      time_in       = time_ff;
      time_fc_in    = time_fc_ff;
      frac1_in      = frac1_ff;
      frac2_in      = frac2_ff;
      date_in       = date_ff;
      lat_in        = lat_ff;
      lat_fc_in     = lat_fc_ff;
      lon_in        = lon_ff;
      lon_fc_in     = lon_fc_ff;
      kept_in       = kept_ff;
      clear         = 1'b0;
      push          = 1'b0;
      if (accept) begin
         priority if (ch == CHAR_DOLLAR) begin
            clear = 1'b1;
         end else if (ch == CHAR_LF) begin
            clear = 1'b0;
         end else if (ch == CHAR_CR) begin
            push  = 1'b1;
            clear = 1'b1;
            if (ok) begin
               kept_in = fresh;
            end
         end else if (char_count_ff < 8'(LINE_LIMIT)) begin
            char_count_in = char_count_ff + 8'd1;
            if (after_star_ff) begin
               if (!hex_ok || (sum_cnt_ff >= SUM_DONE)) begin
                  sum_cnt_in = SUM_BAD;
               end else begin
                  rx_sum_in  = {rx_sum_ff[3:0], hex_val};
                  sum_cnt_in = sum_cnt_ff + 3'd1;
               end
            end else if (ch == CHAR_STAR) begin
               after_star_in = 1'b1;
            end else begin
               xor_in = xor_ff ^ ch;
               if (ch == CHAR_COMMA) begin
                  if (field_ff < 5'(MAX_FIELDS)) begin
                     field_in = field_ff + 5'd1;
                  end
               end else begin
                  unique case (field_ff)
                     FLD_TYPE: begin
                        if ((type_ff < TYPE_DONE) && (ch == type_char(type_ff))) begin
                           type_in = type_ff + 3'd1;
                        end else begin
                           type_in = TYPE_BAD;
                        end
                     end
                     FLD_TIME: begin
                        if ((ch == CHAR_DOT) && (time_fc_ff == 2'd0)) begin
                           time_fc_in = 2'd1;
                        end else if (is_digit) begin
                           if (time_fc_ff == 2'd0) begin
                              time_in = {time_ff[4:0], dig};
                           end else if (time_fc_ff < TIME_FRAC_END) begin
                              if (time_fc_ff == 2'd1) begin
                                 frac1_in = dig;
                              end else begin
                                 frac2_in = dig;
                              end
                              time_fc_in = time_fc_ff + 2'd1;
                           end
                        end
                     end
                     FLD_STATUS: begin
                        if (status_len_ff == 2'd0) begin
                           status_a_in = (ch == CHAR_STATUS_OK);
                        end
                        if (status_len_ff < 2'd2) begin
                           status_len_in = status_len_ff + 2'd1;
                        end
                     end
                     FLD_LAT: begin
                        if ((ch == CHAR_DOT) && (lat_fc_ff == 3'd0)) begin
                           lat_fc_in = 3'd1;
                        end else if (is_digit && (lat_fc_ff < COORD_FRAC_END)) begin
                           lat_in = 27'(coord_step({3'b000, lat_ff}, lat_fc_ff, dig, LAT_CAP));
                           if (lat_fc_ff != 3'd0) begin
                              lat_fc_in = lat_fc_ff + 3'd1;
                           end
                        end
                     end
                     FLD_LON: begin
                        if ((ch == CHAR_DOT) && (lon_fc_ff == 3'd0)) begin
                           lon_fc_in = 3'd1;
                        end else if (is_digit && (lon_fc_ff < COORD_FRAC_END)) begin
                           lon_in = coord_step(lon_ff, lon_fc_ff, dig, LON_CAP);
                           if (lon_fc_ff != 3'd0) begin
                              lon_fc_in = lon_fc_ff + 3'd1;
                           end
                        end
                     end
                     FLD_DATE: begin
                        if (is_digit) begin
                           date_in = {date_ff[4:0], dig};
                        end
                     end
                     default: begin
                        type_in = type_ff;
                     end
                  endcase
               end
            end
         end
      end
      if (clear) begin
         char_count_in = '0;
         field_in      = '0;
         xor_in        = '0;
         after_star_in = 1'b0;
         rx_sum_in     = '0;
         sum_cnt_in    = '0;
         type_in       = '0;
         status_a_in   = 1'b0;
         status_len_in = '0;
         time_in       = '0;
         time_fc_in    = '0;
         frac1_in      = '0;
         frac2_in      = '0;
         date_in       = '0;
         lat_in        = '0;
         lat_fc_in     = '0;
         lon_in        = '0;
         lon_fc_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff  <= '0;
         field_ff       <= '0;
         xor_ff         <= '0;
         after_star_ff  <= 1'b0;
         rx_sum_ff      <= '0;
         sum_cnt_ff     <= '0;
         type_ff        <= '0;
         status_a_ff    <= 1'b0;
         status_len_ff  <= '0;
         time_ff        <= '0;
         time_fc_ff     <= '0;
         frac1_ff       <= '0;
         frac2_ff       <= '0;
         date_ff        <= '0;
         lat_ff         <= '0;
         lat_fc_ff      <= '0;
         lon_ff         <= '0;
         lon_fc_ff      <= '0;
         // all kept values zero but the year
         kept_ff        <= {57'd0, YEAR_BASE, 42'd0};
      end else begin
         char_count_ff <= char_count_in;
         field_ff      <= field_in;
         xor_ff        <= xor_in;
         after_star_ff <= after_star_in;
         rx_sum_ff     <= rx_sum_in;
         sum_cnt_ff    <= sum_cnt_in;
         type_ff       <= type_in;
         status_a_ff   <= status_a_in;
         status_len_ff <= status_len_in;
         time_ff       <= time_in;
         time_fc_ff    <= time_fc_in;
         frac1_ff      <= frac1_in;
         frac2_ff      <= frac2_in;
         date_ff       <= date_in;
         lat_ff        <= lat_in;
         lat_fc_ff     <= lat_fc_in;
         lon_ff        <= lon_in;
         lon_fc_ff     <= lon_fc_in;
         kept_ff       <= kept_in;
      end
   end

   nmearmc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign req_tready = buf_ready;
   assign rsp_tdata  = {1'b0, out_item.data};
   assign rsp_tuser  = out_item.updated;

endmodule

// ----- sv/nmearmc_checker.sv -----
module nmearmc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [7:0]                          req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [nmearmc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                                rsp_tuser
);
   import nmearmc_pkg::*;

   logic cr_transfer;
   assign cr_transfer = req_tvalid && req_tready && (req_tdata == CHAR_CR);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // end of line always yields a result
   assert property (@(posedge clock) disable iff (reset)
      cr_transfer |=> rsp_tvalid)
      else $error("no result after end of line");

   // no result appears without an end of line
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !cr_transfer |=> !rsp_tvalid)
      else $error("result without end of line");

   // reported year stays in this century
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[53:42] >= 12'd2000) && (rsp_tdata[53:42] <= 12'd2099))
      else $error("year out of range");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind nmea_rmc_sentence_parser_unit nmearmc_checker u_nmearmc_checker (.*);
